// File: design/irpd_pkg.sv
// Shared types, register indexes and reset values of the IR pulse decoder.
package irpd_pkg;

    // Configuration register file
    localparam int CFG_REGS     = 8;
    localparam int CFG_IDX_W    = $clog2(CFG_REGS);
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LOW   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_HIGH  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_LOW    = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HIGH   = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REP_LOW    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REP_HIGH   = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_LOW   = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_HIGH  = 4'd7;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_REGS] = '{
        16'd300, 16'd800, 16'd1400, 16'd1900, 16'd2200, 16'd2700, 16'd4200, 16'd4700
    };

    // Default build parameters
    localparam int DEF_TIMEOUT_TICKS = 14;
    localparam int DEF_WORD_BITS     = 32;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int CAP_W   = 16;
    localparam int OUT_W   = 32;
    localparam int CNT_W   = 8;
    localparam int TICK_W  = 4;
    localparam int RES_W   = OUT_W + CNT_W + 4 + TICK_W;

    // Event kinds on the input stream
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_CAPTURE = 2'd1,
        MODE_ACK     = 2'd2
    } t_mode;

    // One result item, packed lowest field last so that it maps onto tdata
    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic              restart_timer;
        logic              awaiting_falling;
        logic              frame_done;
        logic              lead_seen;
        logic [CNT_W-1:0]  repeat_count;
        logic [OUT_W-1:0]  received_word;
    } t_result;

endpackage

// File: design/irpd_core.sv
// Input register, configuration registers and the pulse decoding state.
module irpd_core
    import irpd_pkg::*;
#(
    parameter int TIMEOUT_TICKS = DEF_TIMEOUT_TICKS,
    parameter int WORD_BITS     = DEF_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [CAP_W-1:0]      i_capture,
    input  logic                  i_space,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output logic                  o_fire,
    output t_result               o_result
);

    logic                  r_in_valid;
    logic [MODE_W-1:0]     r_in_mode;
    logic [CAP_W-1:0]      r_in_capture;
    logic [CFG_DATA_W-1:0] r_cfg [CFG_REGS];

    logic                  r_lead, n_lead;
    logic                  r_done, n_done;
    logic                  r_rising, n_rising;
    logic [TICK_W-1:0]     r_ticks, n_ticks;
    logic [WORD_BITS-1:0]  r_shift, n_shift;
    logic [CNT_W-1:0]      r_rep, n_rep;
    logic                  n_restart;
    logic                  in_zero, in_one, in_rep, in_lead;
    logic [OUT_W-1:0]      word_out;

    assign o_busy = r_in_valid;
    assign o_fire = r_in_valid && i_space;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_load) begin
            r_in_valid <= 1'b1;
        end else if (o_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in_mode    <= i_mode;
            r_in_capture <= i_capture;
        end
    end

    // Configuration registers; writes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we && (i_cfg_index < CFG_ADDR_W'(CFG_REGS))) begin
            r_cfg[i_cfg_index[CFG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Exclusive width windows
    assign in_zero = (r_in_capture > r_cfg[CFG_ZERO_LOW[CFG_IDX_W-1:0]]) &&
                     (r_in_capture < r_cfg[CFG_ZERO_HIGH[CFG_IDX_W-1:0]]);
    assign in_one  = (r_in_capture > r_cfg[CFG_ONE_LOW[CFG_IDX_W-1:0]]) &&
                     (r_in_capture < r_cfg[CFG_ONE_HIGH[CFG_IDX_W-1:0]]);
    assign in_rep  = (r_in_capture > r_cfg[CFG_REP_LOW[CFG_IDX_W-1:0]]) &&
                     (r_in_capture < r_cfg[CFG_REP_HIGH[CFG_IDX_W-1:0]]);
    assign in_lead = (r_in_capture > r_cfg[CFG_LEAD_LOW[CFG_IDX_W-1:0]]) &&
                     (r_in_capture < r_cfg[CFG_LEAD_HIGH[CFG_IDX_W-1:0]]);

    // Next state for the event in the input register
    always_comb begin
        n_lead    = r_lead;
        n_done    = r_done;
        n_rising  = r_rising;
        n_ticks   = r_ticks;
        n_shift   = r_shift;
        n_rep     = r_rep;
        n_restart = 1'b0;
        unique case (t_mode'(r_in_mode))
            MODE_TICK: begin
                if (r_lead) begin
                    n_rising = 1'b0;
                    if (r_ticks == '0) begin
                        n_done = 1'b1;
                    end
                    if (r_ticks < TICK_W'(TIMEOUT_TICKS)) begin
                        n_ticks = r_ticks + TICK_W'(1);
                    end else begin
                        n_lead  = 1'b0;
                        n_ticks = '0;
                    end
                end
            end
            MODE_CAPTURE: begin
                if (!r_rising) begin
                    // rising edge: restart the timer and wait for the falling one
                    n_rising  = 1'b1;
                    n_restart = 1'b1;
                end else begin
                    n_rising = 1'b0;
                    if (r_lead) begin
                        priority if (in_zero) begin
                            n_shift = {r_shift[WORD_BITS-2:0], 1'b0};
                        end else if (in_one) begin
                            n_shift = {r_shift[WORD_BITS-2:0], 1'b1};
                        end else if (in_rep) begin
                            n_rep   = r_rep + CNT_W'(1);
                            n_ticks = '0;
                        end else begin
                            n_shift = r_shift;
                        end
                    end else if (in_lead) begin
                        n_lead = 1'b1;
                        n_rep  = '0;
                    end
                end
            end
            MODE_ACK: begin
                n_done = 1'b0;
            end
            default: begin
                n_done = r_done;
            end
        endcase
    end

    // Decoder state, updated as each event moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= 1'b0;
            r_done   <= 1'b0;
            r_rising <= 1'b0;
            r_ticks  <= '0;
            r_shift  <= '0;
            r_rep    <= '0;
        end else if (o_fire) begin
            r_lead   <= n_lead;
            r_done   <= n_done;
            r_rising <= n_rising;
            r_ticks  <= n_ticks;
            r_shift  <= n_shift;
            r_rep    <= n_rep;
        end
    end

    // Low bits of the shift register as the reported word
    generate
        if (WORD_BITS >= OUT_W) begin : g_word_wide
            assign word_out = n_shift[OUT_W-1:0];
        end else begin : g_word_narrow
            assign word_out = {{(OUT_W-WORD_BITS){1'b0}}, n_shift};
        end
    endgenerate

    always_comb begin
        o_result.received_word    = word_out;
        o_result.repeat_count     = n_rep;
        o_result.lead_seen        = n_lead;
        o_result.frame_done       = n_done;
        o_result.awaiting_falling = n_rising;
        o_result.restart_timer    = n_restart;
        o_result.tick_count       = n_ticks;
    end

endmodule

// File: design/irpd_outbuf.sv
// Result register with a skid entry so the input side never waits on tready directly.
module irpd_outbuf
    import irpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves: skid drains first, otherwise a new request lands
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

// File: design/ir_remote_pulse_decoder.sv
// Top level of the NEC-style infrared remote pulse decoder.
//
// Input stream: one request per timer event. tuser carries the event kind
// (overflow tick, capture edge, frame acknowledge), tdata the captured
// timer count in microseconds. Output stream: one request per event with
// the decoder state after that event plus the restart_timer pulse.
// Configuration: eight 16-bit window bounds written through i_cfg_*; the
// port is always ready and should only be written while no event is in
// flight.
//
// An accepted event passes the input register, then the window compares and
// state update into the result register. One event is taken every cycle
// while the output side has space; the limit is the single state update
// stage, which holds all decoder state. Reset (synchronous, active low)
// clears the decoder state, reloads the default windows and empties both
// stages. When the receiver stalls, one more result parks in a skid entry,
// then the input register fills and o_s_axis_tready drops until the output
// drains.
module ir_remote_pulse_decoder
    import irpd_pkg::*;
#(
    parameter int TIMEOUT_TICKS = DEF_TIMEOUT_TICKS,
    parameter int WORD_BITS     = DEF_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [15:0] capture_value
    input  logic [7:0]            i_s_axis_tuser,   // [1:0] mode, rest zero
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [31:0] received_word, [39:32] repeat_count, [40] lead_seen,
    // [41] frame_done, [42] awaiting_falling, [43] restart_timer, [47:44] tick_count
    output logic [RES_W-1:0]      o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    busy;
    logic    fire;
    logic    space;
    t_result core_res;
    t_result out_res;

    assign o_s_axis_tready = !busy || space;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tdata  = out_res;

    irpd_core #(
        .TIMEOUT_TICKS (TIMEOUT_TICKS),
        .WORD_BITS     (WORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_s_axis_tvalid && o_s_axis_tready),
        .i_mode      (i_s_axis_tuser[MODE_W-1:0]),
        .i_capture   (i_s_axis_tdata),
        .i_space     (space),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_fire      (fire),
        .o_result    (core_res)
    );

    irpd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_result (core_res),
        .i_ready  (i_m_axis_tready),
        .o_space  (space),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_res)
    );

endmodule

// File: design/irpd_checker.sv
// Port-level checks of the IR pulse decoder, bound to the top level.
module irpd_checker
    import irpd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [RES_W-1:0] o_m_axis_tdata
);

    // A timer restart only comes from a rising edge, which arms the falling one
    a_restart_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[43]) |-> o_m_axis_tdata[42])
        else $error("restart_timer without awaiting_falling");

    // Tick counter only runs inside a frame; timeout clears both together
    a_ticks_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[40]) |-> (o_m_axis_tdata[47:44] == 4'd0))
        else $error("tick_count nonzero with no lead-in");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output request changed while stalled");

endmodule

bind ir_remote_pulse_decoder irpd_checker u_irpd_checker (.*);
